// ===== src/icpr_pkg.sv =====
package icpr_pkg;

   localparam int PE_COUNT    = 16;
   localparam int LANES       = 16;
   localparam int WEIGHT_ROWS = 512;

   localparam int ROW_BYTES    = 16;
   localparam int OUT_BYTES    = 16;
   localparam int ACC_W        = 32;
   localparam int REQ_SHIFT    = 8;
   localparam int SAT_MAX      = 127;
   localparam int SAT_MIN      = -128;
   localparam int PROD_W       = 16;
   localparam int GROUP_SIZE   = 4;
   localparam int GROUPS       = ROW_BYTES / GROUP_SIZE;
   localparam int PART_W       = PROD_W + 2;
   localparam int DOT_W        = PART_W + 2;
   localparam int ACTIVE_LANES = (LANES < ROW_BYTES) ? LANES : ROW_BYTES;
   localparam int MEM_ROWS     = (WEIGHT_ROWS < 512) ? WEIGHT_ROWS : 512;
   localparam int MEM_ADDR_W   = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;
   localparam int PE_IDX_W     = (PE_COUNT > 1) ? $clog2(PE_COUNT) : 1;
   localparam int FIFO_DEPTH   = 2 ** $clog2(PE_COUNT + 8);
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_MAC  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type     command;
      logic [3:0]  pe_index;
      logic [8:0]  weight_row;
      logic [63:0] data_lo;
      logic [63:0] data_hi;
      logic        pad;
      logic        first;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [63:0] result_lo;
      logic [63:0] result_hi;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type data;
   } chain_type;

   typedef struct packed {
      logic                       valid;
      logic [OUT_BYTES-1:0][7:0]  bytes;
   } res_chain_type;

   typedef struct packed {
      logic mac;
      logic first;
      logic last;
   } stage_type;

endpackage

// ===== src/icpr_cell.sv =====
module icpr_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [icpr_pkg::PE_IDX_W-1:0]   cell_index,
   input  icpr_pkg::chain_type             req_in,
   output icpr_pkg::chain_type             req_out,
   input  icpr_pkg::res_chain_type         res_in,
   output icpr_pkg::res_chain_type         res_out
);

   localparam int RowW = icpr_pkg::ROW_BYTES * 8;
   localparam int REQ_SHIFT_W = icpr_pkg::REQ_SHIFT;

   logic [RowW-1:0] wmem [icpr_pkg::MEM_ROWS];

   icpr_pkg::chain_type fwd_ff;
   logic [RowW-1:0] rd_data_ff;
   logic [icpr_pkg::ROW_BYTES-1:0][7:0] act_ff, act_in;
   icpr_pkg::stage_type st1_ff, st2_ff, st3_ff, st4_ff, st1_in;
   logic signed [icpr_pkg::PROD_W-1:0] prod_ff [icpr_pkg::ROW_BYTES];
   logic signed [icpr_pkg::PROD_W-1:0] prod_in [icpr_pkg::ROW_BYTES];
   logic signed [icpr_pkg::PART_W-1:0] part_ff [icpr_pkg::GROUPS];
   logic signed [icpr_pkg::PART_W-1:0] part_in [icpr_pkg::GROUPS];
   logic signed [icpr_pkg::DOT_W-1:0] dot_ff, dot_in;
   logic [icpr_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic emit_ff, emit_in;
   icpr_pkg::res_chain_type res_ff, res_in_next;
   logic [7:0] q_byte;
   logic signed [icpr_pkg::ACC_W-REQ_SHIFT_W-1:0] shifted;

   logic row_ok, sel_ok, wr_en, is_mac;
   logic [icpr_pkg::MEM_ADDR_W-1:0] addr;
   logic [RowW-1:0] wr_data;

   assign is_mac  = req_in.valid && (req_in.data.command == icpr_pkg::CMD_MAC);
   assign row_ok  = 32'(req_in.data.weight_row) < icpr_pkg::MEM_ROWS;
   assign sel_ok  = 32'(req_in.data.pe_index) == 32'(cell_index);
   assign wr_en   = req_in.valid && (req_in.data.command == icpr_pkg::CMD_LOAD)
                    && sel_ok && row_ok;
   assign addr    = req_in.data.weight_row[icpr_pkg::MEM_ADDR_W-1:0];
   assign wr_data = {req_in.data.data_hi, req_in.data.data_lo};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wmem[addr] <= wr_data;
      end
      rd_data_ff <= wmem[addr];
   end

   always_comb begin
      for (int i = 0; i < icpr_pkg::ROW_BYTES; i++) begin
         if (is_mac && !req_in.data.pad && row_ok && (i < icpr_pkg::ACTIVE_LANES)) begin
            act_in[i] = wr_data[8*i +: 8];
         end else begin
            act_in[i] = 8'd0;
         end
      end
      st1_in.mac   = is_mac;
      st1_in.first = req_in.data.first;
      st1_in.last  = req_in.data.last;
   end

   always_comb begin
      for (int i = 0; i < icpr_pkg::ROW_BYTES; i++) begin
         prod_in[i] = $signed(act_ff[i]) * $signed(rd_data_ff[8*i +: 8]);
      end
   end

   always_comb begin
      for (int g = 0; g < icpr_pkg::GROUPS; g++) begin
         part_in[g] = '0;
         for (int k = 0; k < icpr_pkg::GROUP_SIZE; k++) begin
            part_in[g] = part_in[g]
                         + icpr_pkg::PART_W'(prod_ff[g*icpr_pkg::GROUP_SIZE + k]);
         end
      end
   end

   always_comb begin
      dot_in = '0;
      for (int g = 0; g < icpr_pkg::GROUPS; g++) begin
         dot_in = dot_in + icpr_pkg::DOT_W'(part_ff[g]);
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (st4_ff.mac) begin
         acc_in = (st4_ff.first ? '0 : acc_ff) + icpr_pkg::ACC_W'(dot_ff);
      end
      emit_in = st4_ff.mac && st4_ff.last;
   end

   assign shifted = $signed(acc_ff[icpr_pkg::ACC_W-1:REQ_SHIFT_W]);

   always_comb begin
      if (shifted > icpr_pkg::SAT_MAX) begin
         q_byte = 8'(icpr_pkg::SAT_MAX);
      end else if (shifted < icpr_pkg::SAT_MIN) begin
         q_byte = 8'(icpr_pkg::SAT_MIN);
      end else begin
         q_byte = shifted[7:0];
      end
      res_in_next.valid = emit_ff;
      for (int b = 0; b < icpr_pkg::OUT_BYTES; b++) begin
         if (32'(cell_index) == b) begin
            res_in_next.bytes[b] = q_byte;
         end else begin
            res_in_next.bytes[b] = res_in.bytes[b];
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_ff.data <= req_in.data;
      act_ff      <= act_in;
      prod_ff     <= prod_in;
      part_ff     <= part_in;
      dot_ff      <= dot_in;
      res_ff.bytes <= res_in_next.bytes;
      if (reset) begin
         fwd_ff.valid <= 1'b0;
         st1_ff       <= '0;
         st2_ff       <= '0;
         st3_ff       <= '0;
         st4_ff       <= '0;
         acc_ff       <= '0;
         emit_ff      <= 1'b0;
         res_ff.valid <= 1'b0;
      end else begin
         fwd_ff.valid <= req_in.valid;
         st1_ff       <= st1_in;
         st2_ff       <= st1_ff;
         st3_ff       <= st2_ff;
         st4_ff       <= st3_ff;
         acc_ff       <= acc_in;
         emit_ff      <= emit_in;
         res_ff.valid <= res_in_next.valid;
      end
   end

   assign req_out = fwd_ff;
   assign res_out = res_ff;

endmodule

// ===== src/icpr_fifo.sv =====
module icpr_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  icpr_pkg::rsp_type push_data,
   input  logic              pop,
   output logic              not_empty,
   output icpr_pkg::rsp_type head_data
);

   icpr_pkg::rsp_type mem [icpr_pkg::FIFO_DEPTH];
   icpr_pkg::rsp_type head_ff;

   logic [icpr_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [icpr_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [icpr_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic head_valid_ff, head_valid_in;
   logic do_pop, head_free, mem_any, take_mem, take_push, mem_wr;

   assign not_empty = head_valid_ff;
   assign head_data = head_ff;
   assign do_pop    = pop && head_valid_ff;
   assign head_free = !head_valid_ff || do_pop;
   assign mem_any   = count_ff != '0;
   assign take_mem  = head_free && mem_any;
   assign take_push = head_free && !mem_any && push;
   assign mem_wr    = push && !take_push;

   always_comb begin
      wr_ptr_in = mem_wr   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take_mem ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + icpr_pkg::FIFO_CNT_W'(mem_wr)
                  - icpr_pkg::FIFO_CNT_W'(take_mem);
      head_valid_in = head_valid_ff;
      if (head_free) begin
         head_valid_in = mem_any || push;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (take_mem) begin
         head_ff <= mem[rd_ptr_ff];
      end else if (take_push) begin
         head_ff <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         head_valid_ff <= head_valid_in;
      end
   end

endmodule

// ===== src/int8_conv_pe_array_requant.sv =====
// An int8 convolution datapath built from a chain of processing elements.
// A request on the req_ channel either loads one 16-byte weight row into the
// store of the element named by pe_index, or performs one MAC step in which
// all elements multiply the 16 activations with the addressed weight row and
// add the dot product into their own 32-bit accumulators. A MAC request with
// last set produces one response on the rsp_ channel carrying one saturated
// byte per element; all other requests produce no response.
// Each request walks down the chain one element per cycle, so elements work
// on successive requests at the same time and one request is accepted every
// cycle while req_stall is low. Inside each element the request passes a
// five-stage multiply, add and accumulate pipeline. Responses wait in a
// queue of 32 entries; req_stall rises only when the queue and the
// responses still in flight would fill it, so a stalled receiver is
// absorbed for a while before requests are held back.
// Synchronous reset clears the accumulators, the chain and the queue; the
// weight stores hold no defined content until rows are loaded.
module int8_conv_pe_array_requant (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  icpr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output icpr_pkg::rsp_type rsp_data
);

   icpr_pkg::chain_type     req_chain [icpr_pkg::PE_COUNT+1];
   icpr_pkg::res_chain_type res_chain [icpr_pkg::PE_COUNT+1];

   logic [icpr_pkg::FIFO_CNT_W-1:0] credit_ff, credit_in;
   logic req_accept, rsp_accept, reserve;
   icpr_pkg::rsp_type push_data;
   logic [icpr_pkg::OUT_BYTES*8-1:0] flat;

   assign req_stall  = credit_ff == icpr_pkg::FIFO_CNT_W'(icpr_pkg::FIFO_DEPTH);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign reserve    = req_accept && (req_data.command == icpr_pkg::CMD_MAC)
                       && req_data.last;

   always_comb begin
      credit_in = credit_ff + icpr_pkg::FIFO_CNT_W'(reserve)
                  - icpr_pkg::FIFO_CNT_W'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   assign req_chain[0].valid = req_accept;
   assign req_chain[0].data  = req_data;
   assign res_chain[0]       = '0;

   for (genvar p = 0; p < icpr_pkg::PE_COUNT; p++) begin : g_pe
      icpr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (icpr_pkg::PE_IDX_W'(p)),
         .req_in     (req_chain[p]),
         .req_out    (req_chain[p+1]),
         .res_in     (res_chain[p]),
         .res_out    (res_chain[p+1])
      );
   end

   assign flat                = res_chain[icpr_pkg::PE_COUNT].bytes;
   assign push_data.result_lo = flat[63:0];
   assign push_data.result_hi = flat[127:64];

   icpr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_chain[icpr_pkg::PE_COUNT].valid),
      .push_data (push_data),
      .pop       (rsp_accept),
      .not_empty (rsp_valid),
      .head_data (rsp_data)
   );

endmodule
